FILE: design/windowed_watchdog_timer_macros.svh
// ----------------------------------------------------------------------------
// Windowed watchdog timer assertion macros
// Shared assertion wrappers. They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_WATCHDOG_TIMER_MACROS_SVH
`define WINDOWED_WATCHDOG_TIMER_MACROS_SVH

`ifndef SYNTH
// Clocked check that is ignored while reset is asserted.
`define WWDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define WWDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WWDT_ASSERT(lbl, prop, msg)
`define WWDT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/wwdt_pkg.sv
// ----------------------------------------------------------------------------
// Windowed watchdog timer package
// Request codes, register map, mode and status bit positions and the
// payload types shared by the watchdog modules.
// ----------------------------------------------------------------------------
package wwdt_pkg;

  // Request types.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Register word indexes.
  localparam logic [1:0] REG_CTRL   = 2'd0;
  localparam logic [1:0] REG_MODE   = 2'd1;
  localparam logic [1:0] REG_STATUS = 2'd2;

  // Restart key in control bits 31..24.
  localparam logic [7:0] CTRL_KEY = 8'hA5;

  // Field widths.
  localparam int CNT_W  = 12;
  localparam int MODE_W = 30;
  localparam int DIV_W  = 16;
  localparam int DATA_W = 32;

  // Mode word bit positions.
  localparam int MODE_FIEN_BIT  = 12;
  localparam int MODE_RSTEN_BIT = 13;
  localparam int MODE_DIS_BIT   = 15;
  localparam int MODE_WIN_LSB   = 16;

  // Status flag bit positions.
  localparam int STAT_UNF_BIT = 0;
  localparam int STAT_ERR_BIT = 1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [1:0]        reg_select;
    logic [DATA_W-1:0] write_data;
  } wwdt_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic              reset_request;
  } wwdt_result_t;

endpackage

FILE: design/wwdt_if.sv
// ----------------------------------------------------------------------------
// Windowed watchdog timer channels
// Valid/ready channels for watchdog requests and results.
// ----------------------------------------------------------------------------
interface wwdt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] reg_select;
  logic [wwdt_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output req_type, output reg_select, output write_data,
                  input ready);
  modport sink (input valid, input req_type, input reg_select, input write_data,
                output ready);
endinterface

interface wwdt_out_if;
  logic valid;
  logic ready;
  logic [wwdt_pkg::DATA_W-1:0] read_data;
  logic irq;
  logic reset_request;

  modport source (output valid, output read_data, output irq, output reset_request,
                  input ready);
  modport sink (input valid, input read_data, input irq, input reset_request,
                output ready);
endinterface

FILE: design/wwdt_prescaler.sv
// ----------------------------------------------------------------------------
// Watchdog prescaler
// Holds the clock divider register and counts master ticks into one counter
// decrement per divider period. A divider of zero freezes the prescaler.
// ----------------------------------------------------------------------------
`include "windowed_watchdog_timer_macros.svh"

module wwdt_prescaler #(
  parameter int PRESCALE_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [wwdt_pkg::DIV_W-1:0] cfg_data,
  input  logic                       tick_en,
  output logic                       period_done
);

  // Compare width covers both the incremented count and the divider.
  localparam int CMP_W = (PRESCALE_WIDTH + 1 > wwdt_pkg::DIV_W + 1) ?
                         PRESCALE_WIDTH + 1 : wwdt_pkg::DIV_W + 1;

  logic [wwdt_pkg::DIV_W-1:0] divider_r;
  logic [PRESCALE_WIDTH-1:0]  count_r;
  logic [PRESCALE_WIDTH-1:0]  count_nxt;
  logic [CMP_W-1:0]           count_inc;
  logic [CMP_W-1:0]           div_ext;
  logic                       period_open;

  assign count_inc   = CMP_W'(count_r) + CMP_W'(1);
  assign div_ext     = CMP_W'(divider_r);
  assign period_open = count_inc < div_ext;

  // A period ends on the tick that brings the count up to the divider.
  always_comb begin
    count_nxt   = count_r;
    period_done = 1'b0;
    if (tick_en && (divider_r != '0)) begin
      if (period_open) begin
        count_nxt = count_inc[PRESCALE_WIDTH-1:0];
      end else begin
        count_nxt   = '0;
        period_done = 1'b1;
      end
    end
  end

  // Divider register and prescale count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r <= wwdt_pkg::DIV_W'(1);
      count_r   <= '0;
    end else begin
      if (cfg_we) begin
        divider_r <= cfg_data;
      end
      count_r <= count_nxt;
    end
  end

  `WWDT_ASSERT(a_period_clears_count, period_done |=> (count_r == '0), "prescale count not cleared")

endmodule

FILE: design/wwdt_core.sv
// ----------------------------------------------------------------------------
// Watchdog core
// Down counter, one-time mode register and sticky status flags. Applies one
// request per cycle when fired; forms read data, interrupt and reset request.
// ----------------------------------------------------------------------------
`include "windowed_watchdog_timer_macros.svh"

module wwdt_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  wwdt_pkg::wwdt_req_t    req,
  input  logic                   period_done,
  output logic                   tick_en,
  output wwdt_pkg::wwdt_result_t res
);

  logic [wwdt_pkg::CNT_W-1:0]  down_counter_r;
  logic [wwdt_pkg::CNT_W-1:0]  down_counter_nxt;
  logic [wwdt_pkg::MODE_W-1:0] mode_word_r;
  logic [wwdt_pkg::MODE_W-1:0] mode_word_nxt;
  logic                        mode_locked_r;
  logic                        mode_locked_nxt;
  logic [1:0]                  status_r;
  logic [1:0]                  status_nxt;
  logic [wwdt_pkg::CNT_W-1:0]  window;
  logic                        restart;

  assign tick_en = fire && (req.req_type == wwdt_pkg::REQ_TICK);
  assign window  = mode_word_r[wwdt_pkg::MODE_WIN_LSB +: wwdt_pkg::CNT_W];
  assign restart = (req.write_data[31:24] == wwdt_pkg::CTRL_KEY) && req.write_data[0];

  // Request decode and next state.
  always_comb begin
    down_counter_nxt  = down_counter_r;
    mode_word_nxt     = mode_word_r;
    mode_locked_nxt   = mode_locked_r;
    status_nxt        = status_r;
    res.read_data     = '0;
    res.reset_request = 1'b0;
    if (fire) begin
      case (req.req_type)
        wwdt_pkg::REQ_TICK: begin
          if (period_done && (down_counter_r != '0)) begin
            down_counter_nxt = down_counter_r - wwdt_pkg::CNT_W'(1);
            if ((down_counter_nxt == '0) && !mode_word_r[wwdt_pkg::MODE_DIS_BIT]) begin
              status_nxt[wwdt_pkg::STAT_UNF_BIT] = 1'b1;
              res.reset_request = mode_word_r[wwdt_pkg::MODE_RSTEN_BIT];
            end
          end
        end
        wwdt_pkg::REQ_READ: begin
          case (req.reg_select)
            wwdt_pkg::REG_MODE:   res.read_data = wwdt_pkg::DATA_W'(mode_word_r);
            wwdt_pkg::REG_STATUS: res.read_data = wwdt_pkg::DATA_W'(status_r);
            default:              res.read_data = '0;
          endcase
        end
        wwdt_pkg::REQ_WRITE: begin
          case (req.reg_select)
            wwdt_pkg::REG_CTRL: begin
              // A restart inside the window reloads; outside it flags an error.
              if (restart) begin
                if (down_counter_r <= window) begin
                  down_counter_nxt = mode_word_r[wwdt_pkg::CNT_W-1:0];
                end else begin
                  status_nxt[wwdt_pkg::STAT_ERR_BIT] = 1'b1;
                end
              end
            end
            wwdt_pkg::REG_MODE: begin
              if (!mode_locked_r) begin
                mode_locked_nxt = 1'b1;
                mode_word_nxt   = req.write_data[wwdt_pkg::MODE_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    res.irq = mode_word_nxt[wwdt_pkg::MODE_FIEN_BIT] && (status_nxt != '0);
  end

  // Watchdog state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_counter_r <= '0;
      mode_word_r    <= '0;
      mode_locked_r  <= 1'b0;
      status_r       <= '0;
    end else begin
      down_counter_r <= down_counter_nxt;
      mode_word_r    <= mode_word_nxt;
      mode_locked_r  <= mode_locked_nxt;
      status_r       <= status_nxt;
    end
  end

  `WWDT_ASSERT(a_mode_stays_locked, mode_locked_r |=> mode_locked_r, "mode lock released")
  `WWDT_ASSERT(a_underflow_sticky, status_r[0] |=> status_r[0], "underflow flag cleared")
  `WWDT_ASSERT(a_count_rises_on_restart, !(fire && (req.req_type == wwdt_pkg::REQ_WRITE)) |=> (down_counter_r <= $past(down_counter_r)), "counter rose without restart")

endmodule

FILE: design/windowed_watchdog_timer.sv
// ----------------------------------------------------------------------------
// Windowed watchdog timer
// Top level: request register, watchdog core and prescaler, result register.
// ----------------------------------------------------------------------------
// The block takes one request (master tick, register read or register write)
// in every cycle unless stalled, and returns one result for each, in order.
// A request is held in the request register, where the core and the prescaler
// apply it in a single pass (a compare and a decrement); its result is loaded
// into the result register at the edge on which the request leaves. The result
// register lets a new request enter while a finished result still waits;
// back-pressure on the result side stalls the request side only when both
// registers are full. The user must write the clock divider through
// cfg_we/cfg_data only while the block is idle; the block does not enforce it.
`include "windowed_watchdog_timer_macros.svh"

module windowed_watchdog_timer #(
  parameter int PRESCALE_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  wwdt_in_if.sink                    in_ch,
  wwdt_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [wwdt_pkg::DIV_W-1:0] cfg_data
);

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  wwdt_pkg::wwdt_req_t    s1_req_r;
  logic                   s1_fire;
  logic                   in_acc;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  wwdt_pkg::wwdt_result_t out_res_r;
  wwdt_pkg::wwdt_result_t core_res;
  logic                   tick_en;
  logic                   period_done;

  // Handshake control between the two registers.
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Request and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r.req_type   <= in_ch.req_type;
      s1_req_r.reg_select <= in_ch.reg_select;
      s1_req_r.write_data <= in_ch.write_data;
    end
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  wwdt_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_fire),
    .req         (s1_req_r),
    .period_done (period_done),
    .tick_en     (tick_en),
    .res         (core_res)
  );

  wwdt_prescaler #(
    .PRESCALE_WIDTH (PRESCALE_WIDTH)
  ) u_prescaler (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .tick_en     (tick_en),
    .period_done (period_done)
  );

  // Result channel.
  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = out_res_r.read_data;
  assign out_ch.irq           = out_res_r.irq;
  assign out_ch.reset_request = out_res_r.reset_request;

  `WWDT_ASSERT(a_stage_holds_request, (s1_valid_r && !s1_fire) |=> s1_valid_r, "held request lost")

endmodule
